FILE: rtl/brfb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the byte ring FIFO burst core.
// No dependencies; the top level, controller and datapath import this package.
package brfb_pkg;

  localparam int BYTE_W  = 8;
  localparam int GLEN_W  = 7;
  localparam int MOVED_W = 9;
  localparam int CFG_W   = 4;
  localparam int SHIFT_W = 5;

  localparam logic [CFG_W-1:0]   DEPTH_RST = 4'd8;
  localparam logic [MOVED_W-1:0] BURST_SAT = 9'h1FF;

  typedef enum logic {
    ST_IDLE,
    ST_GET
  } brfb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic put;     // put byte taken this cycle
    logic get;     // get request taken this cycle
    logic rd;      // issue one ring read for the open get
  } brfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic get_nonzero;   // the offered get would move at least one byte
    logic rem_one;       // the read issued now is the last one of the get
  } brfb_sts_t;

endpackage

FILE: rtl/byte_ring_fifo_burst_core.sv
`timescale 1ns / 1ps
// Top level of the byte ring FIFO burst core.
// Depends on brfb_pkg and instantiates brfb_ctrl and brfb_datapath.
//
// Usage:
//   Input requests are taken on a rising edge where start is high and busy is low.
//   A put request (in_req_type = 0) stores in_data_byte if the ring has room and
//   drops it otherwise. Puts never raise busy. The put that
//   carries in_burst_last gives one result, in the next cycle, with the number of
//   bytes the burst stored in out_moved_count.
//   A get request (in_req_type = 1) moves the smaller of in_get_length, MAX_GET and
//   the stored count. If that is zero, one result with count 0 appears the next
//   cycle. Otherwise busy stays high while the get issues its n ring reads, one ring
//   read per cycle; the n byte results come from the registered read port of the
//   ring store's single read port, the last marked by out_last_result.
//   Each result is on the out_ ports for one cycle with out_valid high; the receiver
//   cannot stall it. Every result carries the empty and full flags as they stand
//   after the whole request.
//   The cfg_ channel writes depth_log2 (log2 of the capacity in use); cfg_ready is
//   always high and writes are expected only while the block is idle.
//   Synchronous reset empties the FIFO, clears the open burst count and sets
//   depth_log2 to 8. The ring contents are not cleared and need no clearing pass.
module byte_ring_fifo_burst_core
  import brfb_pkg::*;
#(
  parameter int STORE_DEPTH_LOG2 = 8,
  parameter int MAX_GET          = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_burst_last,
  input  logic [GLEN_W-1:0]  in_get_length,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_byte_valid,
  output logic [MOVED_W-1:0] out_moved_count,
  output logic               out_last_result,
  output logic               out_is_empty,
  output logic               out_is_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_depth_log2
);

  brfb_cmd_t cmd;
  brfb_sts_t sts;

  // The register can always be taken; the user writes it only while idle.
  assign cfg_ready = 1'b1;

  brfb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .req_type(in_req_type),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  brfb_datapath #(
    .STORE_DEPTH_LOG2(STORE_DEPTH_LOG2),
    .MAX_GET         (MAX_GET)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data_byte   (in_data_byte),
    .in_burst_last  (in_burst_last),
    .in_get_length  (in_get_length),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_depth_log2 (cfg_depth_log2),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_moved_count(out_moved_count),
    .out_last_result(out_last_result),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

  // A request is never taken while a get is streaming.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.put && !cmd.get)
    else $error("request taken while busy");

  // A byte result always carries a nonzero count.
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_moved_count != '0)
    else $error("byte result with zero moved count");

  // An empty ring is never reported full.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full reported together");

endmodule

FILE: rtl/brfb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module brfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/brfb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the byte ring FIFO burst core.
// Depends on brfb_pkg for the state, command and status types.
module brfb_ctrl
  import brfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      req_type,
  input  brfb_sts_t sts,
  output brfb_cmd_t cmd,
  output logic      busy
);

  brfb_state_t state_r, state_nxt;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    cmd       = '0;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        accept  = start;
        cmd.put = accept & ~req_type;
        cmd.get = accept & req_type;
        if (cmd.get && sts.get_nonzero) begin
          state_nxt = ST_GET;
        end
      end
      ST_GET: begin
        busy   = 1'b1;
        cmd.rd = 1'b1;
        if (sts.rem_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/brfb_datapath.sv
`timescale 1ns / 1ps
// Datapath of the byte ring FIFO burst core: indices, ring store, result registers.
// Depends on brfb_pkg and instantiates brfb_ram.
module brfb_datapath
  import brfb_pkg::*;
#(
  parameter int STORE_DEPTH_LOG2 = 8,
  parameter int MAX_GET          = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  brfb_cmd_t          cmd,
  output brfb_sts_t          sts,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_burst_last,
  input  logic [GLEN_W-1:0]  in_get_length,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_depth_log2,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_byte_valid,
  output logic [MOVED_W-1:0] out_moved_count,
  output logic               out_last_result,
  output logic               out_is_empty,
  output logic               out_is_full
);

  localparam int AW = STORE_DEPTH_LOG2;
  localparam int IW = STORE_DEPTH_LOG2 + 1;
  localparam int CW = (IW > GLEN_W) ? IW : GLEN_W;
  localparam logic [GLEN_W-1:0]  MAX_GET_L = GLEN_W'(MAX_GET);
  localparam logic [SHIFT_W-1:0] SDL_L     = SHIFT_W'(STORE_DEPTH_LOG2);
  localparam logic [IW-1:0]      STORE_L   = IW'(1) << AW;

  logic [CFG_W-1:0]   depth_r;
  logic [IW-1:0]      wi_r, ri_r;
  logic [MOVED_W-1:0] burst_r, burst_nxt;
  logic [GLEN_W-1:0]  rem_r;
  logic               valid_r, byte_sel_r;
  logic               last_r, empty_r, full_r;
  logic [MOVED_W-1:0] moved_r;

  logic [SHIFT_W-1:0] d_eff;
  logic [IW-1:0]      cap, mask, cnt, cnt_after;
  logic               space;
  logic [GLEN_W-1:0]  glen_c, n;
  logic [CW-1:0]      cnt_w, glen_w;
  logic [BYTE_W-1:0]  rd_data;
  logic               ram_we;

  // Capacity in use, with a depth of 0 taken as 1 and the depth clamped to the built store.
  always_comb begin
    if (depth_r == '0) begin
      d_eff = SHIFT_W'(1);
    end else if (SHIFT_W'(depth_r) > SDL_L) begin
      d_eff = SDL_L;
    end else begin
      d_eff = SHIFT_W'(depth_r);
    end
  end

  assign cap   = IW'(1) << d_eff;
  assign mask  = cap - IW'(1);
  assign cnt   = wi_r - ri_r;
  assign space = (cnt < cap);

  // Bytes a get moves: the request clamped to the limit and to the stored count.
  assign glen_c = (in_get_length > MAX_GET_L) ? MAX_GET_L : in_get_length;
  assign cnt_w  = CW'(cnt);
  assign glen_w = CW'(glen_c);
  assign n      = (cnt_w < glen_w) ? GLEN_W'(cnt_w) : glen_c;

  assign cnt_after = cmd.get ? (cnt - IW'(n)) : (cnt + IW'(space));

  assign burst_nxt = (space && burst_r != BURST_SAT) ? burst_r + MOVED_W'(1) : burst_r;

  assign sts.get_nonzero = (n != '0);
  assign sts.rem_one     = (rem_r == GLEN_W'(1));

  assign ram_we = cmd.put & space;

  brfb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(1 << STORE_DEPTH_LOG2)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wi_r[AW-1:0] & mask[AW-1:0]),
    .wdata(in_data_byte),
    .re   (cmd.rd),
    .raddr(ri_r[AW-1:0] & mask[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= DEPTH_RST;
      wi_r       <= '0;
      ri_r       <= '0;
      burst_r    <= '0;
      rem_r      <= '0;
      valid_r    <= 1'b0;
      byte_sel_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      if (cfg_we) begin
        depth_r <= cfg_depth_log2;
      end
      if (ram_we) begin
        wi_r <= wi_r + IW'(1);
      end
      if (cmd.put) begin
        burst_r <= in_burst_last ? '0 : burst_nxt;
        if (in_burst_last) begin
          valid_r    <= 1'b1;
          byte_sel_r <= 1'b0;
        end
      end
      if (cmd.get) begin
        rem_r <= n;
        if (n == '0) begin
          valid_r    <= 1'b1;
          byte_sel_r <= 1'b0;
        end
      end
      if (cmd.rd) begin
        ri_r       <= ri_r + IW'(1);
        rem_r      <= rem_r - GLEN_W'(1);
        valid_r    <= 1'b1;
        byte_sel_r <= 1'b1;
      end
    end
  end

  // Result fields; a get's count and flags are held while its bytes stream out.
  always_ff @(posedge clk) begin
    if ((cmd.put && in_burst_last) || cmd.get) begin
      moved_r <= cmd.get ? MOVED_W'(n) : burst_nxt;
      last_r  <= 1'b1;
      empty_r <= (cnt_after == '0);
      full_r  <= (cnt_after >= cap);
    end else if (cmd.rd) begin
      last_r <= sts.rem_one;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_sel_r ? rd_data : '0;
  assign out_byte_valid  = byte_sel_r;
  assign out_moved_count = moved_r;
  assign out_last_result = last_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full_r;

  a_rd_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> rem_r != '0)
    else $error("ring read issued with no bytes left in the get");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= STORE_L)
    else $error("stored count exceeds the ring store");

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd && sts.rem_one |=> valid_r && byte_sel_r && last_r)
    else $error("final get byte not marked last");

  a_get_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.get && n == '0 |=> valid_r && !byte_sel_r && moved_r == '0)
    else $error("empty get did not give its single result");

endmodule
